// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the texture coordinate blocks.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check with explicit clock and active-low reset
`define ASSERT_CLK(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error(msg);

// clocked check on clk / arst_n of the enclosing module
`define ASSERT_STD(lbl, prop, msg) `ASSERT_CLK(lbl, clk, arst_n, prop, msg)

`endif

// File: hw/rtl/tct_pkg.sv
// Package for the texture coordinate transform and wrap block:
// widths, register codes, wrap mode codes, config struct and saturation.
// No dependencies.
`timescale 1ns / 1ps

package tct_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int COORD_WIDTH = 32;
	localparam int FIELD_W     = 32;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int ROT_W       = 16;
	localparam int ROT_FRAC    = 14;
	localparam int MODE_W      = 3;
	localparam int SAT_W       = COORD_WIDTH + CFG_W + 1;

	localparam int XF_STAGES   = 8;
	localparam int WRAP_STAGES = 3;
	localparam int LATENCY     = XF_STAGES + WRAP_STAGES;

	localparam longint ONE_L = longint'(1) << FRAC_BITS;
	localparam longint COS_L = longint'(1) << ROT_FRAC;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SCALE_U   = 3'd0,
		REG_SCALE_V   = 3'd1,
		REG_ROTATION  = 3'd2,
		REG_OFFSET_U  = 3'd3,
		REG_OFFSET_V  = 3'd4,
		REG_TILE_U    = 3'd5,
		REG_TILE_V    = 3'd6,
		REG_WRAP_MODE = 3'd7
	} cfg_idx_t;

	typedef enum logic [MODE_W-1:0] {
		WRAP_REPEAT = 3'd0,
		WRAP_MIRROR = 3'd1,
		WRAP_CLAMP  = 3'd2,
		WRAP_PLANAR = 3'd3,
		WRAP_CUBIC  = 3'd4
	} wrap_mode_t;

	typedef struct packed {
		logic signed [CFG_W-1:0] scale_u;
		logic signed [CFG_W-1:0] scale_v;
		logic signed [ROT_W-1:0] rot_cos;
		logic signed [ROT_W-1:0] rot_sin;
		logic signed [CFG_W-1:0] offset_u;
		logic signed [CFG_W-1:0] offset_v;
		logic signed [CFG_W-1:0] tile_u;
		logic signed [CFG_W-1:0] tile_v;
		logic [MODE_W-1:0]       wrap_mode;
	} cfg_t;

	typedef struct packed {
		coord_t             u;
		coord_t             v;
		logic [FIELD_W-1:0] raw_u;
		logic [FIELD_W-1:0] raw_v;
	} xf_item_t;

	localparam cfg_t CFG_RST = '{
		scale_u:   CFG_W'(ONE_L),
		scale_v:   CFG_W'(ONE_L),
		rot_cos:   ROT_W'(COS_L),
		rot_sin:   '0,
		offset_u:  '0,
		offset_v:  '0,
		tile_u:    CFG_W'(ONE_L),
		tile_v:    CFG_W'(ONE_L),
		wrap_mode: WRAP_REPEAT
	};

	function automatic coord_t sat_coord(input logic signed [SAT_W-1:0] x);
		coord_t r;
		if ((&x[SAT_W-1:COORD_WIDTH-1]) || !(|x[SAT_W-1:COORD_WIDTH-1])) begin
			r = x[COORD_WIDTH-1:0];
		end else if (x[SAT_W-1]) begin
			r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
		end else begin
			r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

// File: hw/rtl/tct_cfg.sv
// Configuration register file of the texture coordinate block.
// Depends on tct_pkg for register codes and the config struct.
`timescale 1ns / 1ps

module tct_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tct_pkg::CFG_W-1:0]      cfg_data,
	output tct_pkg::cfg_t                  cfg
);
	import tct_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCALE_U:   cfg_q.scale_u  <= cfg_data;
				REG_SCALE_V:   cfg_q.scale_v  <= cfg_data;
				REG_ROTATION: begin
					cfg_q.rot_cos <= cfg_data[ROT_W-1:0];
					cfg_q.rot_sin <= cfg_data[2*ROT_W-1:ROT_W];
				end
				REG_OFFSET_U:  cfg_q.offset_u <= cfg_data;
				REG_OFFSET_V:  cfg_q.offset_v <= cfg_data;
				REG_TILE_U:    cfg_q.tile_u   <= cfg_data;
				REG_TILE_V:    cfg_q.tile_v   <= cfg_data;
				REG_WRAP_MODE: cfg_q.wrap_mode <= cfg_data[MODE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: hw/rtl/tct_xform.sv
// Eight-stage transform pipeline: center, scale, rotate, offset, tile.
// Depends on tct_pkg for widths, the config struct and saturation.
`timescale 1ns / 1ps

module tct_xform (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic signed [tct_pkg::FIELD_W-1:0]  coord_u,
	input  logic signed [tct_pkg::FIELD_W-1:0]  coord_v,
	input  tct_pkg::cfg_t                       cfg,
	output logic                                out_valid,
	output tct_pkg::xf_item_t                   out_item
);
	import tct_pkg::*;

	localparam int PS_W = COORD_WIDTH + CFG_W;
	localparam int PR_W = COORD_WIDTH + ROT_W;
	localparam logic signed [SAT_W-1:0] HALF_S = SAT_W'(longint'(1) << (FRAC_BITS - 1));

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;

	logic [2*FIELD_W-1:0] raw_s1, raw_s2, raw_s3, raw_s4, raw_s5, raw_s6, raw_s7;

	coord_t                  a_u_s1, a_v_s1;
	logic signed [PS_W-1:0]  p_u_s2, p_v_s2;
	coord_t                  b_u_s3, b_v_s3;
	logic signed [PR_W-1:0]  pcu_s4, psv_s4, psu_s4, pcv_s4;
	coord_t                  r_u_s5, r_v_s5;
	coord_t                  t_u_s6, t_v_s6;
	logic signed [PS_W-1:0]  tp_u_s7, tp_v_s7;
	xf_item_t                item_s8;

	logic signed [SAT_W-1:0] ru_sum, rv_sum;

	always_comb begin
		ru_sum = SAT_W'(pcu_s4) - SAT_W'(psv_s4);
		rv_sum = SAT_W'(psu_s4) + SAT_W'(pcv_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
		end
	end

	always_ff @(posedge clk) begin
		raw_s1 <= {coord_u, coord_v};
		a_u_s1 <= sat_coord(SAT_W'(coord_u) - HALF_S);
		a_v_s1 <= sat_coord(SAT_W'(coord_v) - HALF_S);

		raw_s2 <= raw_s1;
		p_u_s2 <= PS_W'(a_u_s1) * PS_W'($signed(cfg.scale_u));
		p_v_s2 <= PS_W'(a_v_s1) * PS_W'($signed(cfg.scale_v));

		raw_s3 <= raw_s2;
		b_u_s3 <= sat_coord(SAT_W'(p_u_s2 >>> FRAC_BITS));
		b_v_s3 <= sat_coord(SAT_W'(p_v_s2 >>> FRAC_BITS));

		raw_s4 <= raw_s3;
		pcu_s4 <= PR_W'(b_u_s3) * PR_W'($signed(cfg.rot_cos));
		psv_s4 <= PR_W'(b_v_s3) * PR_W'($signed(cfg.rot_sin));
		psu_s4 <= PR_W'(b_u_s3) * PR_W'($signed(cfg.rot_sin));
		pcv_s4 <= PR_W'(b_v_s3) * PR_W'($signed(cfg.rot_cos));

		raw_s5 <= raw_s4;
		r_u_s5 <= sat_coord(ru_sum >>> ROT_FRAC);
		r_v_s5 <= sat_coord(rv_sum >>> ROT_FRAC);

		raw_s6 <= raw_s5;
		t_u_s6 <= sat_coord(SAT_W'(sat_coord(SAT_W'(r_u_s5) + HALF_S))
			+ SAT_W'($signed(cfg.offset_u)));
		t_v_s6 <= sat_coord(SAT_W'(sat_coord(SAT_W'(r_v_s5) + HALF_S))
			+ SAT_W'($signed(cfg.offset_v)));

		raw_s7  <= raw_s6;
		tp_u_s7 <= PS_W'(t_u_s6) * PS_W'($signed(cfg.tile_u));
		tp_v_s7 <= PS_W'(t_v_s6) * PS_W'($signed(cfg.tile_v));

		item_s8.raw_u <= raw_s7[2*FIELD_W-1:FIELD_W];
		item_s8.raw_v <= raw_s7[FIELD_W-1:0];
		item_s8.u     <= sat_coord(SAT_W'(tp_u_s7 >>> FRAC_BITS));
		item_s8.v     <= sat_coord(SAT_W'(tp_v_s7 >>> FRAC_BITS));
	end

	assign out_valid = vld_s8;
	assign out_item  = item_s8;

endmodule

// File: hw/rtl/tct_wrap.sv
// Three-stage wrap pipeline: repeat, mirror, clamp, planar and cube face remap.
// Depends on tct_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tct_wrap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  tct_pkg::xf_item_t                   in_item,
	input  tct_pkg::cfg_t                       cfg,
	output logic                                done,
	output logic signed [tct_pkg::FIELD_W-1:0]  wrapped_u,
	output logic signed [tct_pkg::FIELD_W-1:0]  wrapped_v
);
	import tct_pkg::*;

	localparam int SU_W     = COORD_WIDTH + 3;
	localparam int IDX_W    = COORD_WIDTH - FRAC_BITS + 4;
	localparam int IDXM_W   = IDX_W - 1;
	localparam int RECIP_SH = IDXM_W + 3;
	localparam int RECIP_W  = RECIP_SH - 2;
	localparam int PROD_W   = IDXM_W + RECIP_W;
	localparam int Q_W      = PROD_W - RECIP_SH;
	localparam logic [RECIP_W-1:0] RECIP_M =
		RECIP_W'(((longint'(1) << RECIP_SH) + longint'(5)) / 6);
	localparam coord_t ONE_C = coord_t'(ONE_L);
	localparam logic [FRAC_BITS:0] ONE_M = (FRAC_BITS+1)'(ONE_L);
	localparam logic signed [FIELD_W-1:0] ONE_F = FIELD_W'(ONE_C);

	typedef enum logic [2:0] {
		FACE_0 = 3'd0,
		FACE_1 = 3'd1,
		FACE_2 = 3'd2,
		FACE_3 = 3'd3,
		FACE_4 = 3'd4,
		FACE_5 = 3'd5
	} face_t;

	typedef struct packed {
		logic signed [IDX_W-1:0]     idx;
		logic signed [FRAC_BITS:0]   loc;
	} cube_t;

	function automatic cube_t cube_split(input coord_t c);
		logic signed [SU_W-1:0]       s;
		logic [SU_W-1:0]              mag;
		logic [SU_W-FRAC_BITS-1:0]    imag;
		logic [FRAC_BITS:0]           lmag;
		cube_t                        r;
		s    = SU_W'(c) + (SU_W'(c) <<< 1);
		mag  = s[SU_W-1] ? -s : s;
		imag = mag[SU_W-1:FRAC_BITS];
		lmag = {1'b0, mag[FRAC_BITS-1:0]};
		r.idx = s[SU_W-1] ? -IDX_W'(imag) : IDX_W'(imag);
		r.loc = s[SU_W-1] ? -lmag : lmag;
		return r;
	endfunction

	cube_t                    cu, cv;
	logic signed [IDX_W-1:0]  idx;
	logic [FRAC_BITS:0]       m_u, m_v, mir_u, mir_v;
	logic [FIELD_W-1:0]       sel_u, sel_v;

	logic                     vld_s9, vld_s10, vld_s11;
	logic [MODE_W-1:0]        mode_s9, mode_s10, mode_s11;
	logic [FIELD_W-1:0]       sel_u_s9, sel_v_s9, sel_u_s10, sel_v_s10;
	logic signed [FRAC_BITS:0] lu_s9, lv_s9, lu_s10, lv_s10;
	logic                     neg_s9, neg_s10;
	logic [IDXM_W-1:0]        idx_m_s9, idx_m_s10;
	logic [Q_W-1:0]           q_s10;
	logic signed [FIELD_W-1:0] wrapped_u_s11, wrapped_v_s11;

	logic [PROD_W-1:0]        prod;
	logic [IDXM_W-1:0]        six_q, diff;
	face_t                    face;
	logic signed [FIELD_W-1:0] lu_f, lv_f, oml_u, oml_v, fin_u, fin_v;

	always_comb begin
		cu  = cube_split(in_item.u);
		cv  = cube_split(in_item.v);
		idx = cu.idx + cv.idx + (cv.idx <<< 1);

		m_u   = in_item.u[FRAC_BITS:0];
		m_v   = in_item.v[FRAC_BITS:0];
		mir_u = (m_u > ONE_M) ? -m_u : m_u;
		mir_v = (m_v > ONE_M) ? -m_v : m_v;

		case (cfg.wrap_mode)
			WRAP_REPEAT: begin
				sel_u = FIELD_W'(in_item.u[FRAC_BITS-1:0]);
				sel_v = FIELD_W'(in_item.v[FRAC_BITS-1:0]);
			end
			WRAP_MIRROR: begin
				sel_u = FIELD_W'(mir_u);
				sel_v = FIELD_W'(mir_v);
			end
			WRAP_CLAMP: begin
				sel_u = in_item.u[COORD_WIDTH-1] ? '0 :
					((in_item.u > ONE_C) ? FIELD_W'(ONE_C) : FIELD_W'(in_item.u));
				sel_v = in_item.v[COORD_WIDTH-1] ? '0 :
					((in_item.v > ONE_C) ? FIELD_W'(ONE_C) : FIELD_W'(in_item.v));
			end
			WRAP_PLANAR: begin
				sel_u = in_item.raw_u;
				sel_v = in_item.raw_v;
			end
			default: begin
				sel_u = FIELD_W'(in_item.u);
				sel_v = FIELD_W'(in_item.v);
			end
		endcase
	end

	always_comb begin
		prod = PROD_W'(idx_m_s9) * PROD_W'(RECIP_M);
	end

	always_comb begin
		six_q = IDXM_W'({q_s10, 2'b00}) + IDXM_W'({q_s10, 1'b0});
		diff  = idx_m_s10 - six_q;
		face  = face_t'(diff[2:0]);
		lu_f  = FIELD_W'(lu_s10);
		lv_f  = FIELD_W'(lv_s10);
		oml_u = FIELD_W'(ONE_C - coord_t'(lu_s10));
		oml_v = FIELD_W'(ONE_C - coord_t'(lv_s10));
		fin_u = sel_u_s10;
		fin_v = sel_v_s10;
		// a negative face index keeps the transformed pair unless it divides by six
		if (mode_s10 == WRAP_CUBIC && (!neg_s10 || diff == '0)) begin
			case (face)
				FACE_0: begin fin_u = lu_f;  fin_v = lv_f;  end
				FACE_1: begin fin_u = lv_f;  fin_v = oml_u; end
				FACE_2: begin fin_u = oml_u; fin_v = lv_f;  end
				FACE_3: begin fin_u = oml_v; fin_v = oml_u; end
				FACE_4: begin fin_u = lu_f;  fin_v = oml_v; end
				FACE_5: begin fin_u = lu_f;  fin_v = lv_f;  end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s9  <= in_valid;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		mode_s9  <= cfg.wrap_mode;
		sel_u_s9 <= sel_u;
		sel_v_s9 <= sel_v;
		lu_s9    <= cu.loc;
		lv_s9    <= cv.loc;
		neg_s9   <= idx[IDX_W-1];
		idx_m_s9 <= idx[IDX_W-1] ? IDXM_W'(-idx) : idx[IDXM_W-1:0];

		mode_s10  <= mode_s9;
		sel_u_s10 <= sel_u_s9;
		sel_v_s10 <= sel_v_s9;
		lu_s10    <= lu_s9;
		lv_s10    <= lv_s9;
		neg_s10   <= neg_s9;
		idx_m_s10 <= idx_m_s9;
		q_s10     <= prod[PROD_W-1:RECIP_SH];

		mode_s11      <= mode_s10;
		wrapped_u_s11 <= fin_u;
		wrapped_v_s11 <= fin_v;
	end

	assign done      = vld_s11;
	assign wrapped_u = wrapped_u_s11;
	assign wrapped_v = wrapped_v_s11;

	`ASSERT_STD(a_clamp_range, vld_s11 && (mode_s11 == WRAP_CLAMP) |-> !wrapped_u_s11[FIELD_W-1] && (wrapped_u_s11 <= ONE_F) && !wrapped_v_s11[FIELD_W-1] && (wrapped_v_s11 <= ONE_F), "clamp result outside [0,1]")
	`ASSERT_STD(a_repeat_range, vld_s11 && (mode_s11 == WRAP_REPEAT) |-> !wrapped_u_s11[FIELD_W-1] && (wrapped_u_s11 < ONE_F) && !wrapped_v_s11[FIELD_W-1] && (wrapped_v_s11 < ONE_F), "repeat result outside [0,1)")

endmodule

// File: hw/rtl/texture_coordinate_transform_wrap.sv
// Texture coordinate transform and wrap, top level; uses tct_pkg, tct_cfg, tct_xform, tct_wrap.
// Pipeline from start to done: 8 transform stages, then 3 wrap stages.
// Throughput: one item per cycle; busy stays low, the pipeline advances every cycle.
// done strobes for one cycle per item; the receiver cannot stall.
// Reset: arst_n clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module texture_coordinate_transform_wrap (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [tct_pkg::FIELD_W-1:0]  coord_u,
	input  logic signed [tct_pkg::FIELD_W-1:0]  coord_v,
	input  logic                                cfg_we,
	input  logic [tct_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tct_pkg::CFG_W-1:0]           cfg_data,
	output logic                                done,
	output logic signed [tct_pkg::FIELD_W-1:0]  wrapped_u,
	output logic signed [tct_pkg::FIELD_W-1:0]  wrapped_v
);
	import tct_pkg::*;

	cfg_t     cfg;
	logic     accept;
	logic     xf_valid;
	xf_item_t xf_item;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	tct_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tct_xform u_xform (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.cfg       (cfg),
		.out_valid (xf_valid),
		.out_item  (xf_item)
	);

	tct_wrap u_wrap (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (xf_valid),
		.in_item   (xf_item),
		.cfg       (cfg),
		.done      (done),
		.wrapped_u (wrapped_u),
		.wrapped_v (wrapped_v)
	);

	`ASSERT_STD(a_done_latency, done |-> $past(accept, LATENCY), "done without an item accepted at the pipeline latency")

endmodule

// File: dv/tb_texture_coordinate_transform_wrap.sv
// Self-checking testbench for texture_coordinate_transform_wrap: directed table, then
// randomized register settings and coordinates checked against an in-bench predictor.
// Depends on tct_pkg and the texture_coordinate_transform_wrap RTL.
`timescale 1ns / 1ps

module tb_texture_coordinate_transform_wrap;

	import tct_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int SEGMENTS       = 16;
	localparam int SEG_ITEMS      = 112;
	localparam int PRINT_CAP      = 100;
	localparam int DIR_ROWS       = 35;

	localparam logic [MODE_W-1:0] WRAP_RSVD_FIRST = 3'd5;
	localparam logic [MODE_W-1:0] WRAP_RSVD_LAST  = 3'd7;

	typedef enum logic {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef struct packed {
		coord_t u;
		coord_t v;
	} uv_t;

	typedef struct packed {
		logic typed;
		uv_t  uv;
	} typed_uv_t;

	typedef struct packed {
		row_kind_t   kind;
		logic [31:0] a;
		logic [31:0] b;
		logic        typed;
		logic [31:0] eu;
		logic [31:0] ev;
	} dir_row_t;

	logic                    clk;
	logic                    arst_n    = 1'b0;
	logic                    start     = 1'b0;
	logic                    busy;
	logic signed [FIELD_W-1:0] coord_u = '0;
	logic signed [FIELD_W-1:0] coord_v = '0;
	logic                    cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_W-1:0]        cfg_data  = '0;
	logic                    done;
	logic signed [FIELD_W-1:0] wrapped_u;
	logic signed [FIELD_W-1:0] wrapped_v;

	cfg_t      tex_cfg = CFG_RST;
	uv_t       expected_uv [$];
	typed_uv_t typed_uv [$];
	int        err_count   = 0;
	int        stall_count = 0;
	int        gap_pct     = 0;

	texture_coordinate_transform_wrap DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.coord_u   (coord_u),
		.coord_v   (coord_v),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.wrapped_u (wrapped_u),
		.wrapped_v (wrapped_v)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic longint clamp32(longint x);
		longint hi;
		longint lo;
		hi = 64'sh7FFF_FFFF;
		lo = -hi - 1;
		return (x > hi) ? hi : ((x < lo) ? lo : x);
	endfunction

	function automatic longint qmul(longint a, longint b);
		return clamp32((a * b) >>> FRAC_BITS);
	endfunction

	function automatic longint floor_mod(longint x, longint m);
		longint r;
		r = x % m;
		return (r < 0) ? r + m : r;
	endfunction

	function automatic uv_t transform_and_wrap(coord_t in_u, coord_t in_v);
		longint one, half, ou, ov, u, v, cs, sn, ru, rv, wu, wv;
		longint su, sv, iu, iv, lu, lv, face;
		uv_t    r;
		one  = ONE_L;
		half = ONE_L / 2;
		ou   = in_u;
		ov   = in_v;
		cs   = longint'($signed(tex_cfg.rot_cos));
		sn   = longint'($signed(tex_cfg.rot_sin));
		u    = qmul(clamp32(ou - half), longint'($signed(tex_cfg.scale_u)));
		v    = qmul(clamp32(ov - half), longint'($signed(tex_cfg.scale_v)));
		ru   = clamp32((u * cs - v * sn) >>> ROT_FRAC);
		rv   = clamp32((u * sn + v * cs) >>> ROT_FRAC);
		u    = clamp32(clamp32(ru + half) + longint'($signed(tex_cfg.offset_u)));
		v    = clamp32(clamp32(rv + half) + longint'($signed(tex_cfg.offset_v)));
		u    = qmul(u, longint'($signed(tex_cfg.tile_u)));
		v    = qmul(v, longint'($signed(tex_cfg.tile_v)));
		wu   = u;
		wv   = v;
		case (tex_cfg.wrap_mode)
			WRAP_REPEAT: begin
				wu = floor_mod(u, one);
				wv = floor_mod(v, one);
			end
			WRAP_MIRROR: begin
				wu = floor_mod(u, 2 * one);
				wv = floor_mod(v, 2 * one);
				if (wu > one) wu = 2 * one - wu;
				if (wv > one) wv = 2 * one - wv;
			end
			WRAP_CLAMP: begin
				wu = (u < 0) ? 0 : ((u > one) ? one : u);
				wv = (v < 0) ? 0 : ((v > one) ? one : v);
			end
			WRAP_PLANAR: begin
				wu = ou;
				wv = ov;
			end
			WRAP_CUBIC: begin
				su   = 3 * u;
				sv   = 3 * v;
				iu   = su / one;
				iv   = sv / one;
				lu   = su - iu * one;
				lv   = sv - iv * one;
				face = (iu + 3 * iv) % 6;
				case (face)
					0: begin wu = lu;       wv = lv;       end
					1: begin wu = lv;       wv = one - lu; end
					2: begin wu = one - lu; wv = lv;       end
					3: begin wu = one - lv; wv = one - lu; end
					4: begin wu = lu;       wv = one - lv; end
					5: begin wu = lu;       wv = lv;       end
					default: ;
				endcase
			end
			default: ;
		endcase
		r.u = wu[31:0];
		r.v = wv[31:0];
		return r;
	endfunction

	function automatic void store_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
		case (idx)
			REG_SCALE_U:   tex_cfg.scale_u   = d;
			REG_SCALE_V:   tex_cfg.scale_v   = d;
			REG_ROTATION: begin
				tex_cfg.rot_cos = d[15:0];
				tex_cfg.rot_sin = d[31:16];
			end
			REG_OFFSET_U:  tex_cfg.offset_u  = d;
			REG_OFFSET_V:  tex_cfg.offset_v  = d;
			REG_TILE_U:    tex_cfg.tile_u    = d;
			REG_TILE_V:    tex_cfg.tile_v    = d;
			REG_WRAP_MODE: tex_cfg.wrap_mode = d[MODE_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] pick_q16(int span);
		case ($urandom_range(7))
			0: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			1: return 32'(ONE_L);
			2: return $urandom();
			default: return 32'(int'($urandom_range(0, 2 * span)) - span);
		endcase
	endfunction

	function automatic coord_t rand_coord();
		case ($urandom_range(9))
			0: begin
				case ($urandom_range(3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0000;
					default: return 32'(ONE_L);
				endcase
			end
			1, 2: return $urandom();
			default: return 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_rotation();
		int cs;
		int sn;
		cs = int'($urandom_range(0, 32768)) - 16384;
		sn = int'($urandom_range(0, 32768)) - 16384;
		case ($urandom_range(7))
			0: return $urandom();
			1: return 32'(COS_L);
			2: return $urandom_range(1) ? 32'h8000_8000 : 32'h7FFF_7FFF;
			default: return {sn[15:0], cs[15:0]};
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		err_count++;
		if (err_count <= PRINT_CAP)
			$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	task automatic issue_coord(coord_t u, coord_t v, logic typed, coord_t eu, coord_t ev);
		typed_uv_t t;
		cfg_we <= 1'b0;
		while ($urandom_range(99) < gap_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		t.typed = typed;
		t.uv.u  = eu;
		t.uv.v  = ev;
		typed_uv.push_back(t);
		start   <= 1'b1;
		coord_u <= u;
		coord_v <= v;
		do @(posedge clk); while (busy);
	endtask

	task automatic settle_pipeline();
		start <= 1'b0;
		while (expected_uv.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic program_reg(cfg_idx_t idx, logic [CFG_W-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= d;
		store_reg(idx, d);
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		typed_uv_t t;
		uv_t       e;
		logic      took;
		took = arst_n && start && !busy;
		if (took) begin
			if (typed_uv.size() != 0) begin
				t = typed_uv.pop_front();
				if (t.typed)
					expected_uv.push_back(t.uv);
				else
					expected_uv.push_back(transform_and_wrap(coord_u, coord_v));
			end else begin
				expected_uv.push_back(transform_and_wrap(coord_u, coord_v));
			end
		end
		if (arst_n && done) begin
			if (expected_uv.size() == 0) begin
				report_mismatch($sformatf("unexpected result u=%h v=%h", wrapped_u, wrapped_v));
			end else begin
				e = expected_uv.pop_front();
				if (wrapped_u !== e.u)
					report_mismatch($sformatf("wrapped_u got %h want %h", wrapped_u, e.u));
				if (wrapped_v !== e.v)
					report_mismatch($sformatf("wrapped_v got %h want %h", wrapped_v, e.v));
			end
		end
		if (took || done)
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		dir_row_t    dir_rows [DIR_ROWS];
		logic        last_item;
		int          mode_pick;
		logic [31:0] mode_word;
		dir_rows = '{
			'{ROW_ITEM,  32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
			'{ROW_ITEM,  32'h0001_8000, 32'hFFFF_4000, 1'b1, 32'h0000_8000, 32'h0000_4000},
			'{ROW_ITEM,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 32'h0000_FFFF, 32'h0000_8000},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_MIRROR), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0001_8000, 32'hFFFF_4000, 1'b1, 32'h0000_8000, 32'h0000_C000},
			'{ROW_ITEM,  32'h0001_0000, 32'h0002_0000, 1'b1, 32'h0001_0000, 32'h0000_0000},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_CLAMP), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0001_8000, 32'hFFFF_4000, 1'b1, 32'h0001_0000, 32'h0000_0000},
			'{ROW_ITEM,  32'h0000_8000, 32'h0001_0000, 1'b1, 32'h0000_8000, 32'h0001_0000},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_PLANAR), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h1234_5678, 32'h8765_4321, 1'b1, 32'h1234_5678, 32'h8765_4321},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_CUBIC), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0000_8000, 32'h0000_0000, 1'b1, 32'h0000_0000, 32'h0000_8000},
			'{ROW_ITEM,  32'hFFFF_8000, 32'h0000_0000, 1'b1, 32'hFFFF_8000, 32'h0000_0000},
			'{ROW_ITEM,  32'h0001_0000, 32'h0001_0000, 1'b1, 32'h0000_0000, 32'h0000_0000},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_RSVD_FIRST), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0001_8000, 32'hFFFF_4000, 1'b1, 32'h0001_8000, 32'hFFFF_4000},
			'{ROW_WRITE, 32'(REG_SCALE_U),  32'h8000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_SCALE_V),  32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_ROTATION), 32'h7FFF_8000, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_OFFSET_U), 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_OFFSET_V), 32'h8000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_TILE_U),   32'h8000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_TILE_V),   32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_CUBIC), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h8000_0000, 32'h8000_0000, 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0000_1234, 32'hFFFF_ABCD, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_ROTATION), 32'h8000_8000, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_MIRROR), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h0005_4321, 32'hFFFA_1234, 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 32'h0},
			'{ROW_WRITE, 32'(REG_WRAP_MODE), 32'(WRAP_RSVD_LAST), 1'b0, 32'h0, 32'h0},
			'{ROW_ITEM,  32'hFFFF_FFFF, 32'h0000_0001, 1'b0, 32'h0, 32'h0}
		};
		last_item = 1'b0;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_WRITE) begin
				if (last_item)
					settle_pipeline();
				program_reg(cfg_idx_t'(dir_rows[i].a[CFG_IDX_W-1:0]), dir_rows[i].b);
				last_item = 1'b0;
			end else begin
				issue_coord(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed,
					dir_rows[i].eu, dir_rows[i].ev);
				last_item = 1'b1;
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg % 4)
				0: gap_pct = 0;
				1: gap_pct = 64;
				2: gap_pct = 0;
				default: gap_pct = 10;
			endcase
			settle_pipeline();
			if (seg < 8)
				mode_pick = seg;
			else if ($urandom_range(3) == 0)
				mode_pick = $urandom_range(WRAP_RSVD_FIRST, WRAP_RSVD_LAST);
			else
				mode_pick = $urandom_range(WRAP_REPEAT, WRAP_CUBIC);
			mode_word = $urandom();
			mode_word[MODE_W-1:0] = mode_pick[MODE_W-1:0];
			program_reg(REG_SCALE_U, pick_q16(32'h0004_0000));
			program_reg(REG_SCALE_V, pick_q16(32'h0004_0000));
			program_reg(REG_ROTATION, pick_rotation());
			program_reg(REG_OFFSET_U, pick_q16(32'h0008_0000));
			program_reg(REG_OFFSET_V, pick_q16(32'h0008_0000));
			program_reg(REG_TILE_U, pick_q16(32'h0008_0000));
			program_reg(REG_TILE_V, pick_q16(32'h0008_0000));
			program_reg(REG_WRAP_MODE, mode_word);
			for (int n = 0; n < SEG_ITEMS; n++)
				issue_coord(rand_coord(), rand_coord(), 1'b0, '0, '0);
		end

		settle_pipeline();
		repeat (4) @(posedge clk);
		if (expected_uv.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_uv.size()));
		if (err_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
